// File: sv/tccw_pkg.sv
// tccw_pkg: shared types, constants and helper functions for the text console cell writer
// no dependencies; used by tccw_screen_ram and text_console_cell_writer
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 4;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CHAR_W  = 8;
   localparam int CELL_W  = 16;
   localparam int LIN_OUT_W = 11;
   localparam int CSR_W   = 32;
   localparam int CSR_AW  = 3;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACK    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h0F;
   localparam logic [CELL_W-1:0] CELL_RESET  = 16'h0F20;

   typedef enum logic [3:0] {
      OP_PUT_COLOR   = 4'd0,
      OP_PUT_DEFAULT = 4'd1,
      OP_LEFT        = 4'd2,
      OP_RIGHT       = 4'd3,
      OP_UP          = 4'd4,
      OP_DOWN        = 4'd5,
      OP_SET_CURSOR  = 4'd6,
      OP_SET_PROTECT = 4'd7,
      OP_PROTECT_CUR = 4'd8,
      OP_UNPROTECT   = 4'd9,
      OP_CLEAR       = 4'd10,
      OP_READ_CELL   = 4'd11
   } op_type;

   // protected region test; row is one bit wider to cover the row below the screen
   function automatic logic guarded(input logic en, input logic [ROW_W-1:0] prow,
                                    input logic [COL_W-1:0] pcol,
                                    input logic [ROW_W:0] row,
                                    input logic [COL_W-1:0] col);
      logic res;
      res = 1'b0;
      if (en) begin
         if (row < {1'b0, prow}) res = 1'b1;
         else if (row == {1'b0, prow} && col < pcol) res = 1'b1;
      end
      return res;
   endfunction

   // clamp a signed byte into 0..limit-1
   function automatic logic [COL_W-1:0] clamp_pos(input logic signed [7:0] v, input int limit);
      logic [COL_W-1:0] res;
      res = '0;
      if (v < 0) res = '0;
      else if (int'(v) >= limit) res = COL_W'(limit - 1);
      else res = COL_W'(v);
      return res;
   endfunction

endpackage

`default_nettype wire

// File: sv/tccw_screen_ram.sv
// tccw_screen_ram: single-port screen store with registered read data
// depends on tccw_pkg for the cell width and the default depth
`timescale 1ns / 1ps
`default_nettype none

module tccw_screen_ram #(
   parameter int DEPTH  = tccw_pkg::ROWS_DEF * tccw_pkg::COLUMNS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [ADDR_W-1:0]           addr,
   input  wire logic [tccw_pkg::CELL_W-1:0] wdata,
   output logic      [tccw_pkg::CELL_W-1:0] rdata
);

   logic [tccw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tccw_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/text_console_cell_writer.sv
// text_console_cell_writer: character-cell console with a screen store, cursor and protection
// depends on tccw_pkg and tccw_screen_ram
// one beat in work plus one waiting in the response register; a held response stalls the next
// reset: synchronous; a clearing pass over every cell fills the store with 0x0F20,
// no beat is accepted during it, configuration writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_writer #(
   parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS     = tccw_pkg::ROWS_DEF,
   parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [3:0]                        req_operation,
   input  wire logic [tccw_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [tccw_pkg::CHAR_W-1:0]       req_char_color,
   input  wire logic signed [7:0]                 req_target_row,
   input  wire logic signed [7:0]                 req_target_col,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [tccw_pkg::ROW_W-1:0]             rsp_cur_row,
   output logic [tccw_pkg::COL_W-1:0]             rsp_cur_col,
   output logic [tccw_pkg::LIN_OUT_W-1:0]         rsp_cursor_linear,
   output logic                                   rsp_protection_on,
   output logic                                   rsp_scrolled,
   output logic [tccw_pkg::CELL_W-1:0]            rsp_cell_value,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tccw_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [tccw_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [tccw_pkg::CSR_W-1:0]             csr_prdata,
   output logic                                   csr_pready
);

   localparam int ROW_W  = tccw_pkg::ROW_W;
   localparam int COL_W  = tccw_pkg::COL_W;
   localparam int CHAR_W = tccw_pkg::CHAR_W;
   localparam int CELL_W = tccw_pkg::CELL_W;
   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LIN_W  = (ADDR_W > tccw_pkg::LIN_OUT_W) ? ADDR_W : tccw_pkg::LIN_OUT_W;
   localparam int TCNT_W = $clog2(TAB_STOP + 1);
   localparam bit TAB_POW2 = (TAB_STOP & (TAB_STOP - 1)) == 0;
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DECODE, S_TAB_MOD, S_TAB_PUT, S_BS_READ, S_BS_WAIT, S_BS_CHECK,
      S_SCR_READ, S_SCR_WRITE, S_SCR_BLANK, S_FILL, S_RD_ISSUE, S_RD_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // sequencer counters and working registers
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ROW_W-1:0]   arow_ff, arow_in;
   logic [COL_W-1:0]   acol_ff, acol_in;
   logic [COL_W-1:0]   rem_ff, rem_in;
   logic [TCNT_W-1:0]  cnt_ff, cnt_in;
   logic [3:0]         op_ff, op_in;
   logic [CHAR_W-1:0]  ch_ff, ch_in;
   logic [CHAR_W-1:0]  color_ff, color_in;
   logic               scroll_ff, scroll_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;

   // architectural state
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               pen_ff, pen_in;
   logic [ROW_W-1:0]   prow_ff, prow_in;
   logic [COL_W-1:0]   pcol_ff, pcol_in;
   logic [CHAR_W-1:0]  dcolor_ff, dcolor_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]               rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]               rsp_col_ff, rsp_col_in;
   logic [tccw_pkg::LIN_OUT_W-1:0] rsp_lin_ff, rsp_lin_in;
   logic                           rsp_pen_ff, rsp_pen_in;
   logic                           rsp_scr_ff, rsp_scr_in;
   logic [CELL_W-1:0]              rsp_cell_ff, rsp_cell_in;

   // memory port
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [CELL_W-1:0]  mem_rdata;

   // shared row*COLUMNS+col address unit
   logic [ROW_W-1:0]   mul_row;
   logic [COL_W-1:0]   mul_col;
   logic [LIN_W-1:0]   prod;

   // helpers
   logic               accept;
   logic               csr_write;
   logic               cur_guard;
   logic [COL_W:0]     col_inc;
   logic [ROW_W:0]     row_inc;
   logic               mv_ok;
   logic [ROW_W-1:0]   mv_row;
   logic [COL_W-1:0]   mv_col;
   logic [CELL_W-1:0]  blank;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? '0 : {{(tccw_pkg::CSR_W - CHAR_W){1'b0}}, dcolor_ff};

   assign blank   = {dcolor_ff, tccw_pkg::CH_SPACE};
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;
   assign cur_guard = tccw_pkg::guarded(pen_ff, prow_ff, pcol_ff, {1'b0, row_ff}, col_ff);

   // the cursor feeds the address unit while writing at it and when reporting
   always_comb begin
      if (state_ff == S_TAB_PUT || state_ff == S_DONE) begin
         mul_row = row_ff;
         mul_col = col_ff;
      end else begin
         mul_row = arow_ff;
         mul_col = acol_ff;
      end
   end

   assign prod = LIN_W'(mul_row) * LIN_W'(COLUMNS) + LIN_W'(mul_col);

   // cursor moves: target and whether the move is allowed
   always_comb begin
      mv_ok  = 1'b0;
      mv_row = row_ff;
      mv_col = col_ff;
      case (op_ff)
         tccw_pkg::OP_LEFT: begin
            if (col_ff != '0) begin
               mv_col = col_ff - 1'b1;
               mv_ok  = 1'b1;
            end else if (row_ff != '0) begin
               mv_row = row_ff - 1'b1;
               mv_col = COL_LAST;
               mv_ok  = 1'b1;
            end
         end
         tccw_pkg::OP_RIGHT: begin
            if (col_ff != COL_LAST) begin
               mv_col = col_inc[COL_W-1:0];
               mv_ok  = 1'b1;
            end else if (row_ff != ROW_LAST) begin
               mv_row = row_inc[ROW_W-1:0];
               mv_col = '0;
               mv_ok  = 1'b1;
            end
         end
         tccw_pkg::OP_UP: begin
            if (row_ff != '0) begin
               mv_row = row_ff - 1'b1;
               mv_ok  = 1'b1;
            end
         end
         tccw_pkg::OP_DOWN: begin
            if (row_ff != ROW_LAST) begin
               mv_row = row_inc[ROW_W-1:0];
               mv_ok  = 1'b1;
            end
         end
         tccw_pkg::OP_SET_CURSOR: begin
            mv_row = arow_ff;
            mv_col = acol_ff;
            mv_ok  = 1'b1;
         end
         default: begin
            mv_ok = 1'b0;
         end
      endcase
      if (tccw_pkg::guarded(pen_ff, prow_ff, pcol_ff, {1'b0, mv_row}, mv_col)) begin
         mv_ok = 1'b0;
      end
   end

   // memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = prod[ADDR_W-1:0];
      mem_wdata = {color_ff, tccw_pkg::CH_SPACE};
      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = idx_ff;
            mem_wdata = tccw_pkg::CELL_RESET;
         end
         S_FILL, S_SCR_BLANK: begin
            mem_we    = 1'b1;
            mem_addr  = idx_ff;
            mem_wdata = blank;
         end
         S_SCR_READ: begin
            mem_addr = idx_ff + ADDR_W'(COLUMNS);
         end
         S_SCR_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = idx_ff;
            mem_wdata = mem_rdata;
         end
         S_TAB_PUT: begin
            mem_we    = !cur_guard;
            mem_wdata = {color_ff, ch_ff};
         end
         S_BS_CHECK: begin
            mem_we = !tccw_pkg::guarded(pen_ff, prow_ff, pcol_ff, {1'b0, arow_ff}, acol_ff);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      arow_in     = arow_ff;
      acol_in     = acol_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      op_in       = op_ff;
      ch_in       = ch_ff;
      color_in    = color_ff;
      scroll_in   = scroll_ff;
      cell_in     = cell_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pen_in      = pen_ff;
      prow_in     = prow_ff;
      pcol_in     = pcol_ff;
      dcolor_in   = csr_write ? csr_pwdata[CHAR_W-1:0] : dcolor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_lin_in  = rsp_lin_ff;
      rsp_pen_in  = rsp_pen_ff;
      rsp_scr_in  = rsp_scr_ff;
      rsp_cell_in = rsp_cell_ff;

      unique case (state_ff)
         // clearing pass after reset
         S_INIT: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               ch_in     = req_char_code;
               color_in  = (req_operation == tccw_pkg::OP_PUT_COLOR) ? req_char_color : dcolor_ff;
               arow_in   = ROW_W'(tccw_pkg::clamp_pos(req_target_row, ROWS));
               acol_in   = tccw_pkg::clamp_pos(req_target_col, COLUMNS);
               scroll_in = 1'b0;
               cell_in   = '0;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_DONE;
            case (op_ff)
               tccw_pkg::OP_PUT_COLOR, tccw_pkg::OP_PUT_DEFAULT: begin
                  case (ch_ff)
                     tccw_pkg::CH_NEWLINE: begin
                        if (!tccw_pkg::guarded(pen_ff, prow_ff, pcol_ff, row_inc, '0)) begin
                           col_in = '0;
                           if (row_inc >= (ROW_W + 1)'(ROWS)) begin
                              // newline on the last row scrolls everything up
                              row_in    = ROW_LAST;
                              scroll_in = 1'b1;
                              if (prow_ff != '0) prow_in = prow_ff - 1'b1;
                              idx_in    = '0;
                              state_in  = S_SCR_READ;
                           end else begin
                              row_in = row_inc[ROW_W-1:0];
                           end
                        end
                     end
                     tccw_pkg::CH_RETURN: begin
                        if (!tccw_pkg::guarded(pen_ff, prow_ff, pcol_ff, {1'b0, row_ff}, '0)) begin
                           col_in = '0;
                        end
                     end
                     tccw_pkg::CH_BACK: begin
                        if (col_ff != '0) begin
                           arow_in  = row_ff;
                           acol_in  = col_ff - 1'b1;
                           state_in = S_BS_CHECK;
                        end else if (row_ff != '0) begin
                           // scan the row above from its right end
                           arow_in  = row_ff - 1'b1;
                           acol_in  = COL_LAST;
                           state_in = S_BS_READ;
                        end
                     end
                     tccw_pkg::CH_TAB: begin
                        ch_in    = tccw_pkg::CH_SPACE;
                        rem_in   = TAB_POW2 ? (col_ff & COL_W'(TAB_STOP - 1)) : col_ff;
                        state_in = S_TAB_MOD;
                     end
                     default: begin
                        cnt_in   = TCNT_W'(1);
                        state_in = S_TAB_PUT;
                     end
                  endcase
               end
               tccw_pkg::OP_LEFT, tccw_pkg::OP_RIGHT, tccw_pkg::OP_UP, tccw_pkg::OP_DOWN,
               tccw_pkg::OP_SET_CURSOR: begin
                  if (mv_ok) begin
                     row_in = mv_row;
                     col_in = mv_col;
                  end
               end
               tccw_pkg::OP_SET_PROTECT: begin
                  prow_in = arow_ff;
                  pcol_in = acol_ff;
                  pen_in  = 1'b1;
               end
               tccw_pkg::OP_PROTECT_CUR: begin
                  prow_in = row_ff;
                  pcol_in = col_ff;
                  pen_in  = 1'b1;
               end
               tccw_pkg::OP_UNPROTECT: begin
                  pen_in = 1'b0;
               end
               tccw_pkg::OP_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  pen_in   = 1'b0;
                  idx_in   = '0;
                  state_in = S_FILL;
               end
               tccw_pkg::OP_READ_CELL: begin
                  state_in = S_RD_ISSUE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // column modulo tab stop by repeated subtraction
         S_TAB_MOD: begin
            if (rem_ff >= COL_W'(TAB_STOP)) begin
               rem_in = rem_ff - COL_W'(TAB_STOP);
            end else begin
               cnt_in   = TCNT_W'(TAB_STOP) - TCNT_W'(rem_ff);
               state_in = S_TAB_PUT;
            end
         end

         // one character per cycle at the cursor, wrap and corner clamp
         S_TAB_PUT: begin
            if (!cur_guard) begin
               if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
                  if (row_inc >= (ROW_W + 1)'(ROWS)) begin
                     row_in = ROW_LAST;
                     col_in = COL_LAST;
                  end else begin
                     row_in = row_inc[ROW_W-1:0];
                     col_in = '0;
                  end
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == TCNT_W'(1)) begin
               state_in = S_DONE;
            end
         end

         S_BS_READ: begin
            state_in = S_BS_WAIT;
         end

         S_BS_WAIT: begin
            if (mem_rdata[CHAR_W-1:0] != tccw_pkg::CH_SPACE || acol_ff == '0) begin
               state_in = S_BS_CHECK;
            end else begin
               acol_in  = acol_ff - 1'b1;
               state_in = S_BS_READ;
            end
         end

         S_BS_CHECK: begin
            if (!tccw_pkg::guarded(pen_ff, prow_ff, pcol_ff, {1'b0, arow_ff}, acol_ff)) begin
               row_in = arow_ff;
               col_in = acol_ff;
            end
            state_in = S_DONE;
         end

         // scroll copy: read cell one row down, then write it back here
         S_SCR_READ: begin
            state_in = S_SCR_WRITE;
         end

         S_SCR_WRITE: begin
            if (idx_ff == LAST_COPY) begin
               idx_in   = BOTTOM_ROW;
               state_in = S_SCR_BLANK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCR_READ;
            end
         end

         S_SCR_BLANK, S_FILL: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_CELL) begin
               state_in = S_DONE;
            end
         end

         S_RD_ISSUE: begin
            state_in = S_RD_WAIT;
         end

         S_RD_WAIT: begin
            cell_in  = mem_rdata;
            state_in = S_DONE;
         end

         // hold until the response register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_lin_in   = prod[tccw_pkg::LIN_OUT_W-1:0];
               rsp_pen_in   = pen_ff;
               rsp_scr_in   = scroll_ff;
               rsp_cell_in  = cell_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         pen_ff       <= 1'b0;
         prow_ff      <= '0;
         pcol_ff      <= '0;
         dcolor_ff    <= tccw_pkg::COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pen_ff       <= pen_in;
         prow_ff      <= prow_in;
         pcol_ff      <= pcol_in;
         dcolor_ff    <= dcolor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      arow_ff     <= arow_in;
      acol_ff     <= acol_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      color_ff    <= color_in;
      scroll_ff   <= scroll_in;
      cell_ff     <= cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_lin_ff  <= rsp_lin_in;
      rsp_pen_ff  <= rsp_pen_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   tccw_screen_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_screen (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cur_row       = rsp_row_ff;
   assign rsp_cur_col       = rsp_col_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_protection_on = rsp_pen_ff;
   assign rsp_scrolled      = rsp_scr_ff;
   assign rsp_cell_value    = rsp_cell_ff;

   // cursor always stays on the screen
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= ROW_LAST) && (col_ff <= COL_LAST))
      else $error("cursor left the screen");

   // an accepted beat keeps the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready held after accept");

   // the store is never written while waiting for a beat
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("screen written while idle");

   // a scroll always leaves the cursor on the bottom row
   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && scroll_ff) |-> (row_ff == ROW_LAST && col_ff == '0))
      else $error("scroll left cursor off the bottom row");

endmodule

`default_nettype wire

// File: bench/tb_text_console_cell_writer.sv
// testbench for text_console_cell_writer: directed table then random operations, each
// response checked against a behavioural predictor of the screen store; depends on tccw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tb_text_console_cell_writer;

   localparam int NCOL = 80;
   localparam int NROW = 25;
   localparam int TABW = 4;
   localparam int CYCLE_LIMIT = 30000000;
   localparam logic [2:0] ADDR_DEFAULT_COLOR = 3'd0;

   // one expected response beat
   typedef struct packed {
      logic [4:0]  row;
      logic [6:0]  col;
      logic [10:0] lin;
      logic        prot;
      logic        scr;
      logic [15:0] cval;
   } console_rsp_type;

   // directed stimulus row; chk set where the response is typed in
   typedef struct {
      tccw_pkg::op_type op;
      logic [7:0]       ch;
      logic [7:0]       colr;
      logic [7:0]       trow;
      logic [7:0]       tcol;
      bit               chk;
      console_rsp_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_operation = '0;
   logic [7:0] req_char_code = '0;
   logic [7:0] req_char_color = '0;
   logic signed [7:0] req_target_row = '0;
   logic signed [7:0] req_target_col = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [4:0] rsp_cur_row;
   logic [6:0] rsp_cur_col;
   logic [10:0] rsp_cursor_linear;
   logic rsp_protection_on;
   logic rsp_scrolled;
   logic [15:0] rsp_cell_value;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   text_console_cell_writer dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: mirror of the screen store and cursor registers
   logic [15:0] scr_mem [NROW*NCOL];
   logic [7:0]  mdl_color;
   int unsigned cur_r, cur_c, prot_r, prot_c;
   bit          prot_en, scrolled_now;

   console_rsp_type pending_rsp[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  quiet_sender = 0;   // long stretch with no idling
   bit  quiet_sink = 0;

   function automatic bit in_guard(int unsigned r, int unsigned c);
      if (!prot_en) return 0;
      return (r < prot_r) || (r == prot_r && c < prot_c);
   endfunction

   function automatic int unsigned clamp_byte(logic [7:0] raw, int unsigned lim);
      int v;
      v = $signed(raw);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
   endfunction

   function automatic void console_scroll();
      for (int i = 0; i < (NROW-1)*NCOL; i++) scr_mem[i] = scr_mem[i+NCOL];
      for (int i = 0; i < NCOL; i++)
         scr_mem[(NROW-1)*NCOL+i] = {mdl_color, tccw_pkg::CH_SPACE};
      if (prot_r > 0) prot_r--;
      cur_r = NROW - 1;
      scrolled_now = 1;
   endfunction

   function automatic void console_plain(logic [7:0] ch, logic [7:0] colr);
      if (in_guard(cur_r, cur_c)) return;
      scr_mem[cur_r*NCOL+cur_c] = {colr, ch};
      cur_c++;
      if (cur_c >= NCOL) begin
         cur_c = 0;
         cur_r++;
         if (cur_r >= NROW) begin
            cur_r = NROW - 1;
            cur_c = NCOL - 1;
         end
      end
   endfunction

   function automatic void console_put(logic [7:0] ch, logic [7:0] colr);
      int unsigned tr, tc, n;
      tr = cur_r;
      tc = cur_c;
      if (ch == tccw_pkg::CH_NEWLINE) begin
         if (in_guard(cur_r + 1, 0)) return;
         cur_r++;
         cur_c = 0;
         if (cur_r >= NROW) console_scroll();
      end else if (ch == tccw_pkg::CH_RETURN) begin
         if (in_guard(cur_r, 0)) return;
         cur_c = 0;
      end else if (ch == tccw_pkg::CH_BACK) begin
         if (cur_c > 0) tc = cur_c - 1;
         else if (cur_r > 0) begin
            // previous row, last non-space column
            tr = cur_r - 1;
            tc = 0;
            for (int i = NCOL - 1; i >= 0; i--)
               if (scr_mem[tr*NCOL+i][7:0] != tccw_pkg::CH_SPACE) begin
                  tc = i;
                  break;
               end
         end else return;
         if (in_guard(tr, tc)) return;
         cur_r = tr;
         cur_c = tc;
         scr_mem[tr*NCOL+tc] = {colr, tccw_pkg::CH_SPACE};
      end else if (ch == tccw_pkg::CH_TAB) begin
         n = TABW - (cur_c % TABW);
         for (int i = 0; i < n; i++) console_plain(tccw_pkg::CH_SPACE, colr);
      end else console_plain(ch, colr);
   endfunction

   // apply one request to the mirror and return the response it should produce
   function automatic console_rsp_type console_predict(logic [3:0] op, logic [7:0] ch,
         logic [7:0] colr, logic [7:0] trow, logic [7:0] tcol);
      console_rsp_type res;
      int unsigned r, c;
      logic [15:0] peek;
      peek = '0;
      scrolled_now = 0;
      r = cur_r;
      c = cur_c;
      case (op)
         tccw_pkg::OP_PUT_COLOR:   console_put(ch, colr);
         tccw_pkg::OP_PUT_DEFAULT: console_put(ch, mdl_color);
         tccw_pkg::OP_LEFT: begin
            if (c > 0 || r > 0) begin
               if (c > 0) c--;
               else begin
                  r--;
                  c = NCOL - 1;
               end
               if (!in_guard(r, c)) begin
                  cur_r = r;
                  cur_c = c;
               end
            end
         end
         tccw_pkg::OP_RIGHT: begin
            if (c < NCOL - 1 || r < NROW - 1) begin
               if (c < NCOL - 1) c++;
               else begin
                  r++;
                  c = 0;
               end
               if (!in_guard(r, c)) begin
                  cur_r = r;
                  cur_c = c;
               end
            end
         end
         tccw_pkg::OP_UP: if (cur_r != 0 && !in_guard(cur_r - 1, cur_c)) cur_r--;
         tccw_pkg::OP_DOWN: if (cur_r != NROW - 1 && !in_guard(cur_r + 1, cur_c)) cur_r++;
         tccw_pkg::OP_SET_CURSOR: begin
            r = clamp_byte(trow, NROW);
            c = clamp_byte(tcol, NCOL);
            if (!in_guard(r, c)) begin
               cur_r = r;
               cur_c = c;
            end
         end
         tccw_pkg::OP_SET_PROTECT: begin
            prot_r = clamp_byte(trow, NROW);
            prot_c = clamp_byte(tcol, NCOL);
            prot_en = 1;
         end
         tccw_pkg::OP_PROTECT_CUR: begin
            prot_r = cur_r;
            prot_c = cur_c;
            prot_en = 1;
         end
         tccw_pkg::OP_UNPROTECT: prot_en = 0;
         tccw_pkg::OP_CLEAR: begin
            for (int i = 0; i < NROW*NCOL; i++) scr_mem[i] = {mdl_color, tccw_pkg::CH_SPACE};
            cur_r = 0;
            cur_c = 0;
            prot_en = 0;
         end
         tccw_pkg::OP_READ_CELL:
            peek = scr_mem[clamp_byte(trow, NROW)*NCOL + clamp_byte(tcol, NCOL)];
         default: ;
      endcase
      res.row  = 5'(cur_r);
      res.col  = 7'(cur_c);
      res.lin  = 11'(cur_r*NCOL + cur_c);
      res.prot = prot_en;
      res.scr  = scrolled_now;
      res.cval = peek;
      return res;
   endfunction

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random back-pressure, compare each beat with the oldest expectation
   always @(posedge clock) begin
      console_rsp_type w;
      if (reset) rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               w = pending_rsp.pop_front();
               if (rsp_cur_row !== w.row) begin
                  $error("cur_row exp %0d got %0d", w.row, rsp_cur_row);
                  fail_count++;
               end
               if (rsp_cur_col !== w.col) begin
                  $error("cur_col exp %0d got %0d", w.col, rsp_cur_col);
                  fail_count++;
               end
               if (rsp_cursor_linear !== w.lin) begin
                  $error("cursor_linear exp %0d got %0d", w.lin, rsp_cursor_linear);
                  fail_count++;
               end
               if (rsp_protection_on !== w.prot) begin
                  $error("protection_on exp %0d got %0d", w.prot, rsp_protection_on);
                  fail_count++;
               end
               if (rsp_scrolled !== w.scr) begin
                  $error("scrolled exp %0d got %0d", w.scr, rsp_scrolled);
                  fail_count++;
               end
               if (rsp_cell_value !== w.cval) begin
                  $error("cell_value exp %h got %h", w.cval, rsp_cell_value);
                  fail_count++;
               end
            end
         end
         rsp_ready <= quiet_sink || ($urandom_range(99) >= 20);
      end
   end

   // register write: setup cycle then access cycle
   task automatic write_default_color(logic [7:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_DEFAULT_COLOR;
      csr_pwdata  <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mdl_color = val;
   endtask

   // send one request beat, predicting its response at acceptance; valid drops only
   // when the sender idles or stops, so it gets one assignment per time step
   task automatic send_op(logic [3:0] op, logic [7:0] ch, logic [7:0] colr,
                          logic [7:0] trow, logic [7:0] tcol);
      while (!quiet_sender && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_char_code  <= ch;
      req_char_color <= colr;
      req_target_row <= trow;
      req_target_col <= tcol;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(console_predict(op, ch, colr, trow, tcol));
   endtask

   // stop sending and wait until every expected response is back
   task automatic hold_off();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // wait for the block to drain, then pass its longest internal work
   task automatic drain();
      hold_off();
      repeat (5000) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_char();
      case ($urandom_range(9))
         0: return tccw_pkg::CH_NEWLINE;
         1: return tccw_pkg::CH_RETURN;
         2: return tccw_pkg::CH_BACK;
         3: return tccw_pkg::CH_TAB;
         4: return tccw_pkg::CH_SPACE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // random operation mix, mostly writes and edits
   task automatic random_op();
      int k;
      logic [3:0] op;
      k = $urandom_range(99);
      if (k < 55) op = $urandom_range(1) ? tccw_pkg::OP_PUT_COLOR : tccw_pkg::OP_PUT_DEFAULT;
      else if (k < 75) op = 4'($urandom_range(tccw_pkg::OP_DOWN, tccw_pkg::OP_LEFT));
      else if (k < 82) op = tccw_pkg::OP_SET_CURSOR;
      else if (k < 91) op = tccw_pkg::OP_READ_CELL;
      else if (k < 94) op = tccw_pkg::OP_SET_PROTECT;
      else if (k < 96) op = tccw_pkg::OP_PROTECT_CUR;
      else if (k < 98) op = tccw_pkg::OP_UNPROTECT;
      else if (k < 99) op = 4'($urandom_range(15, 12));
      else op = ($urandom_range(3) == 0) ? tccw_pkg::OP_CLEAR : tccw_pkg::OP_UNPROTECT;
      // targets mostly on screen, sometimes anywhere in the signed byte
      send_op(op, rand_char(), 8'($urandom_range(255)),
              8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(NROW-1)),
              8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(NCOL-1)));
   endtask

   stim_row_type plan[$];

   function automatic stim_row_type row_of(tccw_pkg::op_type op, logic [7:0] ch,
         logic [7:0] colr, logic [7:0] tr, logic [7:0] tc, bit chk = 0,
         console_rsp_type want = '0);
      stim_row_type s;
      s.op = op; s.ch = ch; s.colr = colr; s.trow = tr; s.tcol = tc;
      s.chk = chk; s.want = want;
      return s;
   endfunction

   initial begin
      console_rsp_type got;
      for (int i = 0; i < NROW*NCOL; i++) scr_mem[i] = tccw_pkg::CELL_RESET;
      mdl_color = tccw_pkg::COLOR_RESET;
      cur_r = 0; cur_c = 0; prot_r = 0; prot_c = 0; prot_en = 0;

      // directed table: reset state, extremes, control codes, edges, protection
      plan.push_back(row_of(tccw_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'h80, 8'h80, 1,
                            '{0, 0, 0, 0, 0, 16'h0F20}));
      plan.push_back(row_of(tccw_pkg::OP_LEFT, 8'h00, 8'h00, 0, 0, 1, '{0, 0, 0, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_UP, 8'h00, 8'h00, 0, 0, 1, '{0, 0, 0, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_PUT_DEFAULT, tccw_pkg::CH_BACK, 8'h00, 0, 0, 1,
                            '{0, 0, 0, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_PUT_COLOR, 8'hFF, 8'hFF, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_PUT_COLOR, tccw_pkg::CH_TAB, 8'h00, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_PUT_COLOR, tccw_pkg::CH_NEWLINE, 8'h00, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_PUT_COLOR, tccw_pkg::CH_BACK, 8'hA5, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_SET_CURSOR, 0, 0, 8'h7F, 8'h7F, 1,
                            '{24, 79, 1999, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_RIGHT, 0, 0, 0, 0, 1, '{24, 79, 1999, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_DOWN, 0, 0, 0, 0, 1, '{24, 79, 1999, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_PUT_COLOR, 8'h41, 8'h1E, 0, 0, 1,
                            '{24, 79, 1999, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_READ_CELL, 0, 0, 8'h7F, 8'h7F, 1,
                            '{24, 79, 1999, 0, 0, 16'h1E41}));
      plan.push_back(row_of(tccw_pkg::OP_PUT_DEFAULT, tccw_pkg::CH_RETURN, 0, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_PROTECT_CUR, 0, 0, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_SET_PROTECT, 0, 0, 8'd3, 8'd10));
      plan.push_back(row_of(tccw_pkg::OP_PUT_DEFAULT, tccw_pkg::CH_NEWLINE, 0, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_SET_CURSOR, 0, 0, 8'd1, 8'd1));
      plan.push_back(row_of(tccw_pkg::OP_UP, 0, 0, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_UNPROTECT, 0, 0, 0, 0));
      plan.push_back(row_of(tccw_pkg::op_type'(4'd13), 0, 0, 0, 0));
      plan.push_back(row_of(tccw_pkg::OP_CLEAR, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}));
      plan.push_back(row_of(tccw_pkg::OP_READ_CELL, 0, 0, 8'd5, 8'd5, 1,
                            '{0, 0, 0, 0, 0, 16'h0F20}));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_default_color(8'h0F);

      foreach (plan[i]) begin
         send_op(plan[i].op, plan[i].ch, plan[i].colr, plan[i].trow, plan[i].tcol);
         got = pending_rsp[$];
         if (plan[i].chk && got !== plan[i].want) begin
            $error("directed row %0d: table exp %h predictor %h", i, plan[i].want, got);
            fail_count++;
         end
      end
      drain();

      // random phases, default colour swept across its range and extremes
      for (int ph = 0; ph < 6; ph++) begin
         write_default_color(ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : 8'($urandom_range(255)));
         quiet_sender = (ph == 2);
         quiet_sink   = (ph == 2);
         send_op(tccw_pkg::OP_CLEAR, 0, 0, 0, 0);
         for (int n = 0; n < 220; n++) begin
            // bursts of newlines drive scrolling
            if ($urandom_range(49) == 0)
               repeat ($urandom_range(30, 5))
                  send_op(tccw_pkg::OP_PUT_DEFAULT, tccw_pkg::CH_NEWLINE, 0, 0, 0);
            else random_op();
            // sender holds off until every response is back
            if (n == 110) hold_off();
         end
         drain();
      end

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
